// ===== rtl/bcd_minute_second_adjust_counter_top_assert.svh =====
// assertion macros for the bcd mm:ss counter
// used by bcd_minute_second_adjust_counter_top, needs clk and arst_n in scope
`ifndef BCD_MINUTE_SECOND_ADJUST_COUNTER_TOP_ASSERT_SVH
`define BCD_MINUTE_SECOND_ADJUST_COUNTER_TOP_ASSERT_SVH

// checked only out of reset
`define BMSAC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked also during reset
`define BMSAC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bmsac_pkg.sv =====
// shared types and constants of the bcd mm:ss counter
// no dependencies
package bmsac_pkg;

	localparam logic [3:0] UNIT_MAX = 4'd9;
	localparam logic [2:0] TEN_MAX  = 3'd5;

	typedef enum logic [2:0] {
		KIND_INC_SEC = 3'd0,
		KIND_DEC_SEC = 3'd1,
		KIND_INC_MIN = 3'd2,
		KIND_DEC_MIN = 3'd3,
		KIND_LOAD    = 3'd4
	} kind_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       by_ten;
		logic       carry_enable;
		logic [3:0] load_min_tens;
		logic [3:0] load_min_units;
		logic [3:0] load_sec_tens;
		logic [3:0] load_sec_units;
	} cmd_item_t;

	typedef struct packed {
		logic [2:0] min_tens_out;
		logic [3:0] min_units_out;
		logic [2:0] sec_tens_out;
		logic [3:0] sec_units_out;
		logic       is_zero;
	} res_item_t;

	typedef struct packed {
		logic step;
		logic up;
		logic by_ten;
		logic load;
	} cell_ctl_t;

	typedef struct packed {
		logic [2:0] tens;
		logic [3:0] units;
	} pair_t;

endpackage

// ===== rtl/bmsac_cell.sv =====
// one digit-pair cell: tens and units registers with step, load and wrap out
// depends on bmsac_pkg
module bmsac_cell
	import bmsac_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  cell_ctl_t  ctl,
	input  logic       carry_in,
	input  logic [3:0] ld_tens,
	input  logic [3:0] ld_units,
	output pair_t      cur,
	output pair_t      nxt,
	output logic       wrap
);

	logic [2:0] tens_q;
	logic [3:0] units_q;
	logic [2:0] t;
	logic [3:0] u;
	logic       w;

	always_comb begin
		t = tens_q;
		u = units_q;
		w = 1'b0;
		if (ctl.load) begin
			t = (ld_tens > {1'b0, TEN_MAX}) ? TEN_MAX : ld_tens[2:0];
			u = (ld_units > UNIT_MAX) ? UNIT_MAX : ld_units;
		end else if (ctl.step || carry_in) begin
			if (ctl.up) begin
				if (units_q != UNIT_MAX) begin
					u = ctl.by_ten ? UNIT_MAX : units_q + 4'd1;
				end else begin
					u = ctl.by_ten ? UNIT_MAX : 4'd0;
					if (tens_q != TEN_MAX) begin
						t = tens_q + 3'd1;
					end else begin
						t = 3'd0;
						u = 4'd0;
						w = 1'b1;
					end
				end
			end else begin
				if (units_q != 4'd0) begin
					u = ctl.by_ten ? 4'd0 : units_q - 4'd1;
				end else begin
					u = ctl.by_ten ? 4'd0 : UNIT_MAX;
					if (tens_q != 3'd0) begin
						t = tens_q - 3'd1;
					end else begin
						t = TEN_MAX;
						u = UNIT_MAX;
						w = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tens_q  <= '0;
			units_q <= '0;
		end else if (adv) begin
			tens_q  <= t;
			units_q <= u;
		end
	end

	assign cur  = '{tens: tens_q, units: units_q};
	assign nxt  = '{tens: t, units: u};
	assign wrap = w;

endmodule

// ===== rtl/bcd_minute_second_adjust_counter_top.sv =====
// top level of the bcd mm:ss counter: seconds cell chained into minutes cell
// depends on bmsac_pkg, bmsac_cell and the assertion macro header
//
// channel | valid     | stall     | payload
// --------+-----------+-----------+-----------
// command | cmd_valid | cmd_stall | cmd (cmd_item_t)
// result  | res_valid | res_stall | res (res_item_t)
//
// one item per cycle while cmd_stall is low, result registered in the cycle after the item is taken
// the seconds cell hands its wrap to the minutes cell in the same cycle
// reset clears all four digits and the result valid
// cmd_stall rises only while a result is held and res_stall is high
`include "bcd_minute_second_adjust_counter_top_assert.svh"

module bcd_minute_second_adjust_counter_top
	import bmsac_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_item_t cmd,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res
);

	logic      adv;
	logic      res_valid_q;
	res_item_t res_q;
	cell_ctl_t sec_ctl;
	cell_ctl_t min_ctl;
	pair_t     sec_cur;
	pair_t     sec_nxt;
	pair_t     min_cur;
	pair_t     min_nxt;
	logic      sec_wrap;
	logic      min_wrap;
	logic      carry;

	assign cmd_stall = res_valid_q && res_stall;
	assign adv       = cmd_valid && !cmd_stall;

	always_comb begin
		sec_ctl.step   = (cmd.kind == KIND_INC_SEC) || (cmd.kind == KIND_DEC_SEC);
		sec_ctl.up     = (cmd.kind == KIND_INC_SEC);
		sec_ctl.by_ten = cmd.by_ten;
		sec_ctl.load   = (cmd.kind == KIND_LOAD);
		min_ctl.step   = (cmd.kind == KIND_INC_MIN) || (cmd.kind == KIND_DEC_MIN);
		min_ctl.up     = (cmd.kind == KIND_INC_MIN) || (cmd.kind == KIND_INC_SEC);
		min_ctl.by_ten = min_ctl.step && cmd.by_ten;
		min_ctl.load   = (cmd.kind == KIND_LOAD);
	end

	assign carry = sec_wrap && cmd.carry_enable && sec_ctl.step;

	bmsac_cell u_sec (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl      (sec_ctl),
		.carry_in (1'b0),
		.ld_tens  (cmd.load_sec_tens),
		.ld_units (cmd.load_sec_units),
		.cur      (sec_cur),
		.nxt      (sec_nxt),
		.wrap     (sec_wrap)
	);

	bmsac_cell u_min (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl      (min_ctl),
		.carry_in (carry),
		.ld_tens  (cmd.load_min_tens),
		.ld_units (cmd.load_min_units),
		.cur      (min_cur),
		.nxt      (min_nxt),
		.wrap     (min_wrap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.min_tens_out  <= min_nxt.tens;
			res_q.min_units_out <= min_nxt.units;
			res_q.sec_tens_out  <= sec_nxt.tens;
			res_q.sec_units_out <= sec_nxt.units;
			res_q.is_zero       <= (min_nxt == '0) && (sec_nxt == '0);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// a minutes wrap lands on 00 or 59
	`BMSAC_ASSERT(a_digits_range, (sec_cur.tens <= TEN_MAX) && (sec_cur.units <= UNIT_MAX) && (min_cur.tens <= TEN_MAX) && (min_cur.units <= UNIT_MAX), "digit out of bcd range")
	`BMSAC_ASSERT(a_zero_flag, res_valid_q |-> (res_q.is_zero == ((res_q.min_tens_out == 3'd0) && (res_q.min_units_out == 4'd0) && (res_q.sec_tens_out == 3'd0) && (res_q.sec_units_out == 4'd0))), "zero flag disagrees with digits")
	`BMSAC_ASSERT(a_result_follows, adv |=> res_valid_q, "accepted item gave no result")
	`BMSAC_ASSERT(a_state_holds, (res_valid_q && res_stall) |=> ($stable(sec_cur) && $stable(min_cur)), "digits moved while result stalled")
	`BMSAC_ASSERT(a_result_matches, adv |=> ((res_q.sec_tens_out == sec_cur.tens) && (res_q.sec_units_out == sec_cur.units) && (res_q.min_tens_out == min_cur.tens) && (res_q.min_units_out == min_cur.units)), "result differs from stored digits")
	`BMSAC_ASSERT(a_min_wrap_ends, min_wrap |-> ((min_nxt == '0) || ((min_nxt.tens == TEN_MAX) && (min_nxt.units == UNIT_MAX))), "minutes wrap off 00 or 59")

endmodule
